// ----- hw/rtl/rclp_pkg.sv -----
// Shared types, constants and tracker logic for the remote command line parser.
package rclp_pkg;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] ACCEL_CAP     = 16'd100;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] accel;
        logic       brake;
        logic       active;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_EOL,
        KIND_TICK
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic       is_nul;
        logic       is_space;
        logic       is_plus;
        logic       is_minus;
        logic       is_digit;
        logic       is_colon;
        logic       is_a;
        logic       is_b;
        logic [3:0] digit;
    } cls_t;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SPACE,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        prev_letter;
        logic [15:0] value;
        logic        negative;
    } trk_t;

    localparam trk_t TRK_CLEAR = '{phase: PH_SEARCH, prev_letter: 1'b0,
                                   value: 16'd0, negative: 1'b0};

    function automatic trk_t trk_feed(trk_t t, cls_t c, logic letter);
        trk_t r;
        r = t;
        unique case (t.phase)
            PH_SEARCH:
            begin
                if (t.prev_letter && c.is_colon)
                begin
                    r.phase = PH_SPACE;
                end
                r.prev_letter = letter;
            end
            PH_SPACE:
            begin
                priority if (c.is_space)
                begin
                    r.phase = PH_SPACE;
                end
                else if (c.is_plus)
                begin
                    r.phase = PH_DIGITS;
                end
                else if (c.is_minus)
                begin
                    r.negative = 1'b1;
                    r.phase    = PH_DIGITS;
                end
                else if (c.is_digit)
                begin
                    r.value = {12'd0, c.digit};
                    r.phase = PH_DIGITS;
                end
                else
                begin
                    r.phase = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (c.is_digit)
                begin
                    r.value = (t.value << 3) + (t.value << 1) + {12'd0, c.digit};
                end
                else
                begin
                    r.phase = PH_DONE;
                end
            end
            PH_DONE:
            begin
                r = t;
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] trk_result(trk_t t);
        return t.negative ? (16'd0 - t.value) : t.value;
    endfunction

endpackage

// ----- hw/rtl/remote_command_line_parser.sv -----
// A two-entry queue sits between front end and engine; each result is registered.
// Throughput: one item per cycle while the queue has room; the command engine handles
// one queued item a cycle while the result register is empty or being taken.
// Reset: line empty, both field trackers searching, idle count 0, timeout 500 ticks.
// Reset also empties the queue and the result register.
// Top level: APB register, front end, item queue and command engine.
module remote_command_line_parser
#(
    parameter int LINE_BUFFER_SIZE = 48
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rclp_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rclp_pkg::out_item_t out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic           timeout_reg;
    logic [15:0]    timeout_ticks_reg;
    logic [15:0]    timeout_ticks_next;
    logic           cfg_write;
    logic           push;
    rclp_pkg::cls_t push_data;
    logic           q_ready;
    logic           q_valid;
    rclp_pkg::cls_t q_data;
    logic           pop;

    assign timeout_reg = (paddr[1:0] == 2'b00) || (paddr[1:0] != 2'b00);
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready && timeout_reg;
    assign prdata      = {16'd0, timeout_ticks_reg};

    always_comb
    begin
        timeout_ticks_next = cfg_write ? pwdata[15:0] : timeout_ticks_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= rclp_pkg::TIMEOUT_RESET;
        end
        else
        begin
            timeout_ticks_reg <= timeout_ticks_next;
        end
    end

    rclp_front u_front
    (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .q_ready   (q_ready),
        .push      (push),
        .push_data (push_data)
    );

    rclp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    rclp_back
    #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .timeout_ticks (timeout_ticks_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item)
    );

endmodule

// ----- hw/rtl/rclp_front.sv -----
// Front end: accepts input items and classifies them for the command engine.
module rclp_front
(
    input  logic              in_valid,
    output logic              in_ready,
    input  rclp_pkg::in_item_t in_item,
    input  logic              q_ready,
    output logic              push,
    output rclp_pkg::cls_t    push_data
);

    logic [7:0] ch;

    assign ch       = in_item.rx_byte;
    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

    always_comb
    begin
        if (in_item.operation == rclp_pkg::OP_TICK)
        begin
            push_data.kind = rclp_pkg::KIND_TICK;
        end
        else if (ch == rclp_pkg::CH_LF || ch == rclp_pkg::CH_CR)
        begin
            push_data.kind = rclp_pkg::KIND_EOL;
        end
        else
        begin
            push_data.kind = rclp_pkg::KIND_BYTE;
        end
        push_data.is_nul   = (ch == rclp_pkg::CH_NUL);
        push_data.is_space = (ch == rclp_pkg::CH_SPACE) || (ch == rclp_pkg::CH_TAB)
                          || (ch == rclp_pkg::CH_VT) || (ch == rclp_pkg::CH_FF)
                          || (ch == rclp_pkg::CH_LF) || (ch == rclp_pkg::CH_CR);
        push_data.is_plus  = (ch == rclp_pkg::CH_PLUS);
        push_data.is_minus = (ch == rclp_pkg::CH_MINUS);
        push_data.is_digit = (ch >= rclp_pkg::CH_ZERO) && (ch <= rclp_pkg::CH_NINE);
        push_data.is_colon = (ch == rclp_pkg::CH_COLON);
        push_data.is_a     = (ch == rclp_pkg::CH_A);
        push_data.is_b     = (ch == rclp_pkg::CH_B);
        push_data.digit    = ch[3:0];
    end

endmodule

// ----- hw/rtl/rclp_queue.sv -----
// Two-entry queue of classified items between front end and command engine.
module rclp_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rclp_pkg::cls_t push_data,
    output logic           q_ready,
    input  logic           pop,
    output logic           q_valid,
    output rclp_pkg::cls_t q_data
);

    rclp_pkg::cls_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/rclp_back.sv -----
// Command engine: line trackers, idle timer and registered result output.
module rclp_back
#(
    parameter int LINE_BUFFER_SIZE = 48
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  rclp_pkg::cls_t      q_data,
    output logic                pop,
    input  logic [15:0]         timeout_ticks,
    output logic                out_valid,
    input  logic                out_ready,
    output rclp_pkg::out_item_t out_item
);

    localparam int CW = $clog2(LINE_BUFFER_SIZE);
    localparam logic [CW-1:0] LINE_LIMIT = CW'(LINE_BUFFER_SIZE - 1);

    logic [CW-1:0]       line_count_reg;
    logic [CW-1:0]       line_count_next;
    logic                nul_seen_reg;
    logic                nul_seen_next;
    rclp_pkg::trk_t      accel_trk_reg;
    rclp_pkg::trk_t      accel_trk_next;
    rclp_pkg::trk_t      brake_trk_reg;
    rclp_pkg::trk_t      brake_trk_next;
    logic [15:0]         idle_ticks_reg;
    logic [15:0]         idle_ticks_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    rclp_pkg::out_item_t out_item_reg;
    rclp_pkg::out_item_t out_item_next;

    logic                emit;
    rclp_pkg::out_item_t result;
    logic [15:0]         accel_val;
    logic [15:0]         brake_val;
    logic                stored_nul;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign accel_val  = rclp_pkg::trk_result(accel_trk_reg);
    assign brake_val  = rclp_pkg::trk_result(brake_trk_reg);
    assign stored_nul = nul_seen_reg || q_data.is_nul;

    always_comb
    begin
        line_count_next = line_count_reg;
        nul_seen_next   = nul_seen_reg;
        accel_trk_next  = accel_trk_reg;
        brake_trk_next  = brake_trk_reg;
        idle_ticks_next = idle_ticks_reg;
        emit            = 1'b0;
        result          = '0;
        if (pop)
        begin
            unique case (q_data.kind)
                rclp_pkg::KIND_TICK:
                begin
                    emit         = (idle_ticks_reg >= timeout_ticks);
                    result.brake = 1'b1;
                    if (idle_ticks_reg != rclp_pkg::IDLE_MAX)
                    begin
                        idle_ticks_next = idle_ticks_reg + 16'd1;
                    end
                end
                rclp_pkg::KIND_EOL:
                begin
                    if (line_count_reg != '0)
                    begin
                        if (accel_trk_reg.phase != rclp_pkg::PH_SEARCH
                            && brake_trk_reg.phase != rclp_pkg::PH_SEARCH)
                        begin
                            emit            = 1'b1;
                            result.accel    = (accel_val > rclp_pkg::ACCEL_CAP)
                                            ? rclp_pkg::ACCEL_CAP[6:0] : accel_val[6:0];
                            result.brake    = (brake_val[7:0] != 8'd0);
                            result.active   = 1'b1;
                            idle_ticks_next = 16'd0;
                        end
                        line_count_next = '0;
                        nul_seen_next   = 1'b0;
                        accel_trk_next  = rclp_pkg::TRK_CLEAR;
                        brake_trk_next  = rclp_pkg::TRK_CLEAR;
                    end
                end
                rclp_pkg::KIND_BYTE:
                begin
                    if (line_count_reg < LINE_LIMIT)
                    begin
                        line_count_next = line_count_reg + 1'b1;
                        nul_seen_next   = stored_nul;
                        if (!stored_nul)
                        begin
                            accel_trk_next = rclp_pkg::trk_feed(accel_trk_reg, q_data,
                                                                q_data.is_a);
                            brake_trk_next = rclp_pkg::trk_feed(brake_trk_reg, q_data,
                                                                q_data.is_b);
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_item_next = out_item_reg;
        if (pop)
        begin
            out_valid_next = emit;
            out_item_next  = result;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            nul_seen_reg   <= 1'b0;
            accel_trk_reg  <= rclp_pkg::TRK_CLEAR;
            brake_trk_reg  <= rclp_pkg::TRK_CLEAR;
            idle_ticks_reg <= 16'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            nul_seen_reg   <= nul_seen_next;
            accel_trk_reg  <= accel_trk_next;
            brake_trk_reg  <= brake_trk_next;
            idle_ticks_reg <= idle_ticks_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for remote_command_line_parser: fixed and random lines and ticks, checked per item.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_TIMEOUT_ADDR = 2'd0;
    localparam int unsigned LINE_MAX_CHARS  = 47;

    class cmd_scoreboard;
        typedef struct packed {
            rclp_pkg::phase_t phase;
            logic             prev_letter;
            logic [15:0]      value;
            logic             negative;
        } field_t;

        field_t              accel_fld;
        field_t              brake_fld;
        int unsigned         line_len;
        logic                nul_hit;
        logic [15:0]         idle_cnt;
        logic [15:0]         timeout_lim;
        rclp_pkg::out_item_t expected_cmds[$];
        int unsigned         mismatches;

        function new();
            timeout_lim = rclp_pkg::TIMEOUT_RESET;
            idle_cnt    = 16'd0;
            mismatches  = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_len  = 0;
            nul_hit   = 1'b0;
            accel_fld = '{phase: rclp_pkg::PH_SEARCH, prev_letter: 1'b0, value: 16'd0,
                          negative: 1'b0};
            brake_fld = accel_fld;
        endfunction

        function void set_timeout(logic [15:0] v);
            timeout_lim = v;
        endfunction

        function int unsigned pending();
            return expected_cmds.size();
        endfunction

        function field_t feed_field(field_t f, logic [7:0] c, logic [7:0] letter);
            field_t r;
            logic   is_num;
            logic   is_ws;
            r      = f;
            is_num = (c >= rclp_pkg::CH_ZERO) && (c <= rclp_pkg::CH_NINE);
            is_ws  = (c == rclp_pkg::CH_SPACE) || (c == rclp_pkg::CH_TAB)
                     || (c == rclp_pkg::CH_LF) || (c == rclp_pkg::CH_VT)
                     || (c == rclp_pkg::CH_FF) || (c == rclp_pkg::CH_CR);
            case (f.phase)
                rclp_pkg::PH_SEARCH:
                begin
                    if (f.prev_letter && c == rclp_pkg::CH_COLON)
                    begin
                        r.phase = rclp_pkg::PH_SPACE;
                    end
                    r.prev_letter = (c == letter);
                end
                rclp_pkg::PH_SPACE:
                begin
                    if (!is_ws)
                    begin
                        if (c == rclp_pkg::CH_PLUS)
                        begin
                            r.phase = rclp_pkg::PH_DIGITS;
                        end
                        else if (c == rclp_pkg::CH_MINUS)
                        begin
                            r.negative = 1'b1;
                            r.phase    = rclp_pkg::PH_DIGITS;
                        end
                        else if (is_num)
                        begin
                            r.value = 16'(c - rclp_pkg::CH_ZERO);
                            r.phase = rclp_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            r.phase = rclp_pkg::PH_DONE;
                        end
                    end
                end
                rclp_pkg::PH_DIGITS:
                begin
                    if (is_num)
                    begin
                        r.value = f.value * 16'd10 + 16'(c - rclp_pkg::CH_ZERO);
                    end
                    else
                    begin
                        r.phase = rclp_pkg::PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
            return r;
        endfunction

        function logic [15:0] field_value(field_t f);
            return f.negative ? (16'd0 - f.value) : f.value;
        endfunction

        function void note_item(rclp_pkg::in_item_t it);
            logic        fire;
            logic [15:0] a;
            logic [15:0] b;
            if (it.operation == rclp_pkg::OP_TICK)
            begin
                fire = (idle_cnt >= timeout_lim);
                if (idle_cnt != rclp_pkg::IDLE_MAX)
                begin
                    idle_cnt = idle_cnt + 16'd1;
                end
                if (fire)
                begin
                    expected_cmds.push_back('{accel: 7'd0, brake: 1'b1, active: 1'b0});
                end
            end
            else if (it.rx_byte == rclp_pkg::CH_LF || it.rx_byte == rclp_pkg::CH_CR)
            begin
                if (line_len > 0)
                begin
                    if (accel_fld.phase != rclp_pkg::PH_SEARCH
                        && brake_fld.phase != rclp_pkg::PH_SEARCH)
                    begin
                        a = field_value(accel_fld);
                        b = field_value(brake_fld);
                        if (a > rclp_pkg::ACCEL_CAP)
                        begin
                            a = rclp_pkg::ACCEL_CAP;
                        end
                        expected_cmds.push_back('{accel: a[6:0], brake: (b[7:0] != 8'd0),
                                                  active: 1'b1});
                        idle_cnt = 16'd0;
                    end
                    clear_line();
                end
            end
            else if (line_len < LINE_MAX_CHARS)
            begin
                line_len++;
                if (it.rx_byte == rclp_pkg::CH_NUL)
                begin
                    nul_hit = 1'b1;
                end
                if (!nul_hit)
                begin
                    accel_fld = feed_field(accel_fld, it.rx_byte, rclp_pkg::CH_A);
                    brake_fld = feed_field(brake_fld, it.rx_byte, rclp_pkg::CH_B);
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_cmd(rclp_pkg::out_item_t got);
            rclp_pkg::out_item_t exp;
            if (expected_cmds.size() == 0)
            begin
                report_mismatch($sformatf("unexpected command %p", got));
            end
            else
            begin
                exp = expected_cmds.pop_front();
                if (got.accel != exp.accel)
                begin
                    report_mismatch($sformatf("accel %0d, want %0d", got.accel, exp.accel));
                end
                if (got.brake != exp.brake)
                begin
                    report_mismatch($sformatf("brake %0b, want %0b", got.brake, exp.brake));
                end
                if (got.active != exp.active)
                begin
                    report_mismatch($sformatf("active %0b, want %0b", got.active, exp.active));
                end
            end
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    rclp_pkg::in_item_t  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rclp_pkg::out_item_t out_item;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [1:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    cmd_scoreboard sb = new();

    int unsigned items_sent     = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stall_left     = 0;
    logic        stall_kick     = 1'b0;
    logic [15:0] cur_timeout    = rclp_pkg::TIMEOUT_RESET;
    logic [7:0]  line_q[$];

    remote_command_line_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_item(in_item);
            end
            if (out_valid && out_ready)
            begin
                sb.check_cmd(out_item);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_kick)
        begin
            stall_left = 250;
            stall_kick = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        int unsigned gap_pct;
        if (items_sent < 530)
        begin
            gap_pct        = 27;
            recv_stall_pct = 49;
        end
        else if (items_sent < 1060)
        begin
            gap_pct        = 49;
            recv_stall_pct = 27;
        end
        else
        begin
            gap_pct        = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid          = 1'b1;
        in_item.operation = op;
        in_item.rx_byte   = b;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_item(rclp_pkg::OP_BYTE, s[i]);
        end
    endtask

    task automatic send_tick();
        send_item(rclp_pkg::OP_TICK, 8'($urandom));
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_TIMEOUT_ADDR;
        pwdata  = {16'd0, v};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_timeout(v);
        cur_timeout = v;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic add_field(input logic [7:0] letter);
        int unsigned n;
        line_q.push_back(letter);
        line_q.push_back(rclp_pkg::CH_COLON);
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0: line_q.push_back(rclp_pkg::CH_SPACE);
                1: line_q.push_back(rclp_pkg::CH_TAB);
                2: line_q.push_back(rclp_pkg::CH_VT);
                default: line_q.push_back(rclp_pkg::CH_FF);
            endcase
        end
        case ($urandom_range(0, 3))
            0: line_q.push_back(rclp_pkg::CH_PLUS);
            1: line_q.push_back(rclp_pkg::CH_MINUS);
            default:
            begin
            end
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
        repeat (n) line_q.push_back(rclp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_command();
        repeat ($urandom_range(0, 2)) line_q.push_back(text_byte());
        if ($urandom_range(0, 1) == 0)
        begin
            add_field(rclp_pkg::CH_A);
            repeat ($urandom_range(0, 1)) line_q.push_back(text_byte());
            add_field(rclp_pkg::CH_B);
        end
        else
        begin
            add_field(rclp_pkg::CH_B);
            repeat ($urandom_range(0, 1)) line_q.push_back(text_byte());
            add_field(rclp_pkg::CH_A);
        end
        repeat ($urandom_range(0, 1)) line_q.push_back(text_byte());
    endtask

    task automatic build_line();
        int unsigned kind;
        line_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            add_command();
        end
        else if (kind < 75)
        begin
            repeat ($urandom_range(40, 55)) line_q.push_back(text_byte());
            add_command();
        end
        else if (kind < 85)
        begin
            add_command();
            line_q.insert($urandom_range(0, line_q.size()), rclp_pkg::CH_NUL);
        end
        else if (kind < 92)
        begin
            add_field($urandom_range(0, 1) ? rclp_pkg::CH_A : rclp_pkg::CH_B);
            repeat ($urandom_range(0, 3)) line_q.push_back(text_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom));
        end
        line_q.push_back($urandom_range(0, 1) ? rclp_pkg::CH_LF : rclp_pkg::CH_CR);
        if ($urandom_range(0, 9) == 0)
        begin
            line_q.push_back(rclp_pkg::CH_CR);
        end
    endtask

    task automatic run_random_lines(input int unsigned count);
        int unsigned stop_at;
        int          i;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            build_line();
            for (i = 0; i < line_q.size(); i++)
            begin
                if ($urandom_range(0, 99) < 3)
                begin
                    send_tick();
                end
                send_item(rclp_pkg::OP_BYTE, line_q[i]);
            end
            if (cur_timeout <= 30 && $urandom_range(0, 7) == 0)
            begin
                repeat (int'(cur_timeout) + $urandom_range(1, 4)) send_tick();
            end
        end
    endtask

    initial
    begin
        logic [15:0] limits[6];
        int          p;
        int unsigned wait_cnt;
        limits = '{16'd1, 16'd65535, 16'd20, 16'd500, 16'd3, 16'($urandom_range(1, 200))};

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_timeout(16'd2);
        send_text("A:B:5\n");
        send_text("A:-3B:+256\r");
        send_text("\n");
        send_item(rclp_pkg::OP_BYTE, rclp_pkg::CH_NUL);
        send_text("B:A:\n");
        repeat (3) send_tick();
        send_item(rclp_pkg::OP_BYTE, 8'hFF);
        send_text("\r");

        for (p = 0; p < 6; p++)
        begin
            drain_results();
            write_timeout(limits[p]);
            if (p == 0)
            begin
                stall_kick = 1'b1;
                repeat (60) send_tick();
                drain_results();
            end
            run_random_lines(260);
        end

        in_valid = 1'b0;
        for (wait_cnt = 0; wait_cnt < 20000 && sb.pending() != 0; wait_cnt++)
        begin
            @(posedge clk);
        end
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d commands never arrived", sb.pending()));
        end
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("remote_command_line_parser test passed");
        end
        else
        begin
            $display("remote_command_line_parser test failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("remote_command_line_parser test failed");
        $finish;
    end

endmodule
